### hdl/wind_vane_direction_averager_top_defines.svh
// ----------------------------------------------------------------------------
// Wind vane direction averager - assertion macros
// Shared property shapes for the checker; each use expands to one labeled
// concurrent assertion clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WIND_VANE_DIRECTION_AVERAGER_TOP_DEFINES_SVH
`define WIND_VANE_DIRECTION_AVERAGER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define WVDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WVDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/wvda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind vane direction averager - package
// Item types, fixed-point widths and constants, state encodings and the
// CORDIC arctangent step table.
// ----------------------------------------------------------------------------
package wvda_pkg;

   // Default sizes
   localparam int VANE_SAMPLES_DEFAULT     = 16;
   localparam int ANGLE_ITERATIONS_DEFAULT = 16;

   // Field widths
   localparam int RAW_W  = 12;
   localparam int HUND_W = 16;

   // Centered reading c = 2*raw - 4095, range -4095..4095
   localparam int CENT_W = 13;
   localparam logic signed [CENT_W:0] CENT_OFFSET = 14'sd4095;
   localparam int PRE_SHIFT = 8;

   // CORDIC vector and angle formats (angle in degrees * 2^16)
   localparam int XY_W   = 24;
   localparam int Z_W    = 27;
   localparam int STEP_W = 22;
   localparam int TBL_IDX_W = 5;
   localparam int DEG_ONE = 65536;
   localparam logic signed [Z_W-1:0] HALF_TURN_Z = Z_W'(180 * DEG_ONE);
   localparam logic signed [Z_W-1:0] ROT_TURN_Z  = Z_W'(315 * DEG_ONE);
   localparam logic signed [Z_W-1:0] FULL_TURN_Z = Z_W'(360 * DEG_ONE);

   // Wrapped angle and hundredths conversion
   localparam int ANGLE_W = 25;
   localparam int SCALE_W = 32;
   localparam logic [SCALE_W-1:0] HUND_SCALE = SCALE_W'(100);
   localparam logic [SCALE_W-1:0] ROUND_HALF = SCALE_W'(32768);
   localparam logic [HUND_W-1:0]  HUND_TURN  = HUND_W'(36000);
   localparam int HUND_MAX = 35999;

   // Items
   typedef struct packed {
      logic [RAW_W-1:0] vane_x;
      logic [RAW_W-1:0] vane_y;
   } req_item_type;

   typedef struct packed {
      logic [HUND_W-1:0] sample_direction;
      logic [HUND_W-1:0] average_direction;
   } rsp_item_type;

   // Control between sequencer and ring
   typedef struct packed {
      logic fetch;
      logic update;
   } ring_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [HUND_W-1:0] mean;
   } ring_stat_type;

   // State encodings
   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_ANGLE,
      TOP_RING,
      TOP_LOAD
   } top_state_type;

   typedef enum logic [2:0] {
      CORDIC_IDLE,
      CORDIC_SPIN,
      CORDIC_WRAP,
      CORDIC_SCALE,
      CORDIC_ROUND
   } cordic_state_type;

   // round(atan(2^-i) * 2^16) in degrees; nothing past the last entry
   function automatic logic [STEP_W-1:0] step_angle(input logic [TBL_IDX_W-1:0] idx);
      logic [STEP_W-1:0] val;
      case (idx)
         5'd0:    val = STEP_W'(2949120);
         5'd1:    val = STEP_W'(1740967);
         5'd2:    val = STEP_W'(919879);
         5'd3:    val = STEP_W'(466945);
         5'd4:    val = STEP_W'(234379);
         5'd5:    val = STEP_W'(117304);
         5'd6:    val = STEP_W'(58666);
         5'd7:    val = STEP_W'(29335);
         5'd8:    val = STEP_W'(14668);
         5'd9:    val = STEP_W'(7334);
         5'd10:   val = STEP_W'(3667);
         5'd11:   val = STEP_W'(1833);
         5'd12:   val = STEP_W'(917);
         5'd13:   val = STEP_W'(458);
         5'd14:   val = STEP_W'(229);
         5'd15:   val = STEP_W'(115);
         5'd16:   val = STEP_W'(57);
         5'd17:   val = STEP_W'(29);
         5'd18:   val = STEP_W'(14);
         5'd19:   val = STEP_W'(7);
         5'd20:   val = STEP_W'(4);
         5'd21:   val = STEP_W'(2);
         5'd22:   val = STEP_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### hdl/wvda_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind vane direction averager - generic RAM
// Simple dual-port memory: one write port, one read port with registered
// read data. Read data holds when no read is issued.
// ----------------------------------------------------------------------------
module wvda_ram #(
   parameter int WIDTH = wvda_pkg::HUND_W,
   parameter int DEPTH = wvda_pkg::VANE_SAMPLES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/wvda_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind vane direction averager - iterative CORDIC angle unit
// Centers the two readings, runs vectoring-mode CORDIC one step per cycle,
// rotates by -45 degrees modulo a full turn and converts to hundredths.
// ----------------------------------------------------------------------------
module wvda_cordic #(
   parameter int ANGLE_ITERATIONS = wvda_pkg::ANGLE_ITERATIONS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  wvda_pkg::req_item_type      vane,
   output logic                        done,
   output logic [wvda_pkg::HUND_W-1:0] angle
);
   import wvda_pkg::*;

   localparam int ITER_W = (ANGLE_ITERATIONS > 1) ? $clog2(ANGLE_ITERATIONS) : 1;
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ANGLE_ITERATIONS - 1);

   cordic_state_type         state_ff, state_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic signed [XY_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   logic [ANGLE_W-1:0]       wrap_ff, wrap_in;
   logic [SCALE_W-1:0]       prod_ff, prod_in;
   logic [HUND_W-1:0]        angle_ff, angle_in;
   logic                     done_ff, done_in;

   logic signed [CENT_W-1:0] cent_x, cent_y;
   logic signed [XY_W-1:0]   start_x, start_y, dx, dy;
   logic signed [Z_W-1:0]    step_z, rot_z;
   logic [ANGLE_W-1:0]       wrap_val;
   logic [SCALE_W-1:0]       prod_val;
   logic [HUND_W-1:0]        hund_val;

   // Centered readings scaled by 2^8
   assign cent_x  = CENT_W'($signed({1'b0, vane.vane_x, 1'b0}) - CENT_OFFSET);
   assign cent_y  = CENT_W'($signed({1'b0, vane.vane_y, 1'b0}) - CENT_OFFSET);
   assign start_x = {{(XY_W-CENT_W-PRE_SHIFT){cent_x[CENT_W-1]}}, cent_x, {PRE_SHIFT{1'b0}}};
   assign start_y = {{(XY_W-CENT_W-PRE_SHIFT){cent_y[CENT_W-1]}}, cent_y, {PRE_SHIFT{1'b0}}};

   // One micro-rotation: floor shifts and table angle
   assign dx     = y_ff >>> iter_ff;
   assign dy     = x_ff >>> iter_ff;
   assign step_z = $signed({{(Z_W-STEP_W){1'b0}}, step_angle(TBL_IDX_W'(iter_ff))});

   // Rotate by 315 degrees; result is never negative and below two turns
   assign rot_z    = z_ff + ROT_TURN_Z;
   assign wrap_val = (rot_z >= FULL_TURN_Z) ? ANGLE_W'(rot_z - FULL_TURN_Z)
                                            : ANGLE_W'(rot_z);

   // Hundredths, rounded half up
   assign prod_val = SCALE_W'(wrap_ff) * HUND_SCALE + ROUND_HALF;
   assign hund_val = prod_ff[SCALE_W-1 -: HUND_W];

   // Sequencer
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      wrap_in  = wrap_ff;
      prod_in  = prod_ff;
      angle_in = angle_ff;
      done_in  = 1'b0;
      case (state_ff)
         CORDIC_IDLE: begin
            if (start) begin
               iter_in = '0;
               // left half plane: negate vector, start at half turn
               if (cent_x < 0) begin
                  x_in = -start_x;
                  y_in = -start_y;
                  z_in = HALF_TURN_Z;
               end else begin
                  x_in = start_x;
                  y_in = start_y;
                  z_in = '0;
               end
               state_in = CORDIC_SPIN;
            end
         end
         CORDIC_SPIN: begin
            if (!y_ff[XY_W-1]) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + step_z;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - step_z;
            end
            if (iter_ff == LAST_ITER) begin
               iter_in  = '0;
               state_in = CORDIC_WRAP;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         CORDIC_WRAP: begin
            wrap_in  = wrap_val;
            state_in = CORDIC_SCALE;
         end
         CORDIC_SCALE: begin
            prod_in  = prod_val;
            state_in = CORDIC_ROUND;
         end
         CORDIC_ROUND: begin
            // a full turn after rounding reads as zero
            angle_in = (hund_val >= HUND_TURN) ? '0 : hund_val;
            done_in  = 1'b1;
            state_in = CORDIC_IDLE;
         end
         default: begin
            state_in = CORDIC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORDIC_IDLE;
         iter_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      wrap_ff  <= wrap_in;
      prod_ff  <= prod_in;
      angle_ff <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

### hdl/wvda_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind vane direction averager - sample ring and running mean
// Ring of angles in RAM with a running sum. The outgoing entry is read at
// item acceptance, the new angle is written back and the mean is taken as a
// multiply by the reciprocal of the ring size.
// ----------------------------------------------------------------------------
module wvda_ring #(
   parameter int VANE_SAMPLES = wvda_pkg::VANE_SAMPLES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  wvda_pkg::ring_ctrl_type     ctrl,
   input  logic [wvda_pkg::HUND_W-1:0] angle,
   output wvda_pkg::ring_stat_type     stat
);
   import wvda_pkg::*;

   localparam int SLOT_W      = $clog2(VANE_SAMPLES);
   localparam int SUM_W       = $clog2(VANE_SAMPLES * HUND_MAX + 1);
   localparam int RECIP_SHIFT = SUM_W + SLOT_W;
   localparam int RECIP_W     = SUM_W + 2;
   localparam int MEAN_PROD_W = SUM_W + RECIP_W;
   // ceil(2^RECIP_SHIFT / VANE_SAMPLES): exact quotient for every sum
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(VANE_SAMPLES) - 64'd1) / 64'(VANE_SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(VANE_SAMPLES - 1);

   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic                   filled_ff, filled_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   upd_d1_ff, upd_d2_ff;
   logic [MEAN_PROD_W-1:0] prod_ff, prod_in;
   logic [HUND_W-1:0]      old_raw, old_val;

   wvda_ram #(
      .WIDTH (HUND_W),
      .DEPTH (VANE_SAMPLES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.update),
      .wr_addr (slot_ff),
      .wr_data (angle),
      .rd_en   (ctrl.fetch),
      .rd_addr (slot_ff),
      .rd_data (old_raw)
   );

   // Slots not yet written since reset read as zero
   assign old_val = filled_ff ? old_raw : '0;

   // Sum, slot pointer and fill flag
   always_comb begin
      sum_in    = sum_ff;
      slot_in   = slot_ff;
      filled_in = filled_ff;
      if (ctrl.update) begin
         sum_in = sum_ff - SUM_W'(old_val) + SUM_W'(angle);
         if (slot_ff == LAST_SLOT) begin
            slot_in   = '0;
            filled_in = 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   // Mean by reciprocal multiply, registered in the cycle after the sum settles
   assign prod_in = upd_d1_ff ? MEAN_PROD_W'(sum_ff) * MEAN_PROD_W'(RECIP) : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         filled_ff <= 1'b0;
         sum_ff    <= '0;
         upd_d1_ff <= 1'b0;
         upd_d2_ff <= 1'b0;
      end else begin
         slot_ff   <= slot_in;
         filled_ff <= filled_in;
         sum_ff    <= sum_in;
         upd_d1_ff <= ctrl.update;
         upd_d2_ff <= upd_d1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign stat.done = upd_d2_ff;
   assign stat.mean = prod_ff[RECIP_SHIFT +: HUND_W];

endmodule

### hdl/wind_vane_direction_averager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind vane direction averager - top level
// Converts a two-channel vane reading to a direction and keeps a moving
// average of the last VANE_SAMPLES directions.
// ----------------------------------------------------------------------------
// Each item carries two 12-bit vane readings; each result gives the direction
// of that sample and the truncated mean of the ring, both in hundredths of a
// degree (0..35999). The block works on one item at a time and takes the next
// item only once the result of the last is loaded into the output register.
// Each item passes through the CORDIC unit, one micro-rotation per cycle, then
// the wrap, scale and round steps, the ring write back and the reciprocal
// multiply for the mean. A result waiting in the output register does not hold
// off the next item, but a stalled output holds the load of the next result.
// The ring starts at zero after reset and those zeros count in the mean until
// it has filled once.
// ----------------------------------------------------------------------------
module wind_vane_direction_averager_top #(
   parameter int VANE_SAMPLES     = wvda_pkg::VANE_SAMPLES_DEFAULT,
   parameter int ANGLE_ITERATIONS = wvda_pkg::ANGLE_ITERATIONS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wvda_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wvda_pkg::rsp_item_type rsp_data
);
   import wvda_pkg::*;

   top_state_type     state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              out_free;
   logic              cordic_done;
   logic [HUND_W-1:0] cordic_angle;
   ring_ctrl_type     ring_ctrl;
   ring_stat_type     ring_stat;

   wvda_cordic #(
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .vane  (req_data),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   wvda_ring #(
      .VANE_SAMPLES (VANE_SAMPLES)
   ) u_ring (
      .clock (clock),
      .reset (reset),
      .ctrl  (ring_ctrl),
      .angle (cordic_angle),
      .stat  (ring_stat)
   );

   // Item sequencer and output register control
   always_comb begin
      state_in     = state_ff;
      ring_ctrl    = '0;
      rsp_data_in  = rsp_data_ff;
      req_stall    = reset || (state_ff != TOP_IDLE);
      accept       = req_valid && !req_stall;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         TOP_IDLE: begin
            // fetch the outgoing ring entry while the angle is computed
            if (accept) begin
               ring_ctrl.fetch = 1'b1;
               state_in        = TOP_ANGLE;
            end
         end
         TOP_ANGLE: begin
            if (cordic_done) begin
               ring_ctrl.update = 1'b1;
               state_in         = TOP_RING;
            end
         end
         TOP_RING: begin
            if (ring_stat.done) begin
               state_in = TOP_LOAD;
            end
         end
         TOP_LOAD: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.sample_direction  = cordic_angle;
               rsp_data_in.average_direction = ring_stat.mean;
               state_in                      = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hdl/wvda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind vane direction averager - port checker
// Watches the top-level ports: result hold under stall, output ranges and
// one item in flight at a time. Bound to the top level below.
// ----------------------------------------------------------------------------
`include "wind_vane_direction_averager_top_defines.svh"

module wvda_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input wvda_pkg::req_item_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input wvda_pkg::rsp_item_type rsp_data
);
   import wvda_pkg::*;

   logic req_fire;

   assign req_fire = req_valid && !req_stall;

   // A stalled result stays put
   `WVDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // Directions stay below a full turn
   `WVDA_ASSERT_NOW(a_sample_range, clock, reset, rsp_valid, rsp_data.sample_direction < HUND_TURN, "sample direction out of range")
   `WVDA_ASSERT_NOW(a_average_range, clock, reset, rsp_valid, rsp_data.average_direction < HUND_TURN, "average direction out of range")

   // Only one item is worked on at a time
   `WVDA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_fire, req_stall, "second item taken while busy")

   // An accepted item carries fully known readings
   `WVDA_ASSERT_NOW(a_req_known, clock, reset, req_fire, !$isunknown(req_data), "accepted item has unknown bits")

endmodule

bind wind_vane_direction_averager_top wvda_checker u_wvda_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind vane direction averager - testbench
// Drives vane reading pairs through the request channel and checks every
// direction and ring average against a CORDIC and moving-average predictor
// kept in the bench. The handshake pressure rotates through four phases.
// ----------------------------------------------------------------------------
module testbench;
   import wvda_pkg::*;

   localparam int RING_DEPTH  = VANE_SAMPLES_DEFAULT;
   localparam int CORDIC_STEPS = ANGLE_ITERATIONS_DEFAULT;
   localparam int RANDOM_ITEMS = 1480;
   localparam int PHASE_ITEMS  = 150;
   localparam int TAIL_CYCLES  = 2 * (CORDIC_STEPS + 8);
   localparam longint ONE_DEG  = 65536;
   localparam longint TURN     = 360 * ONE_DEG;

   // atan(2^-i) in degrees * 2^16
   localparam longint ATAN_TABLE [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef enum int {
      PH_STEADY,
      PH_SENDER_GAPS,
      PH_RECEIVER_STALLS,
      PH_BOTH_IDLE
   } pressure_phase_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   req_item_type pending_readings[$];
   rsp_item_type expected_directions[$];

   // Predictor state: ring of past directions, next slot and running sum
   logic [HUND_W-1:0] ring_model [RING_DEPTH];
   int unsigned       slot_model = 0;
   int unsigned       sum_model = 0;

   int items_accepted = 0;
   int results_checked = 0;
   int mismatch_count = 0;

   wind_vane_direction_averager_top #(
      .VANE_SAMPLES     (RING_DEPTH),
      .ANGLE_ITERATIONS (CORDIC_STEPS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Direction of one reading pair in hundredths of a degree
   function automatic logic [HUND_W-1:0] vane_direction(input logic [RAW_W-1:0] rx,
                                                        input logic [RAW_W-1:0] ry);
      longint x, y, z, dx, dy, step;
      longint unsigned hund;
      x = (2 * longint'(rx) - 4095) * 256;
      y = (2 * longint'(ry) - 4095) * 256;
      z = 0;
      // left half plane: flip and start from half a turn
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 180 * ONE_DEG;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         step = (i < 24) ? ATAN_TABLE[i] : 0;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + step;
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - step;
         end
      end
      while (z < 0) z = z + TURN;
      while (z >= TURN) z = z - TURN;
      // rotate by -45 degrees
      z = z + 315 * ONE_DEG;
      if (z >= TURN) z = z - TURN;
      hund = (longint'(z) * 100 + 32768) >> 16;
      if (hund >= 36000) hund = 0;
      return HUND_W'(hund);
   endfunction

   // Update the ring model with one accepted item and queue its result
   task automatic predict_reading(input req_item_type item);
      logic [HUND_W-1:0] dir;
      rsp_item_type      want;
      dir = vane_direction(item.vane_x, item.vane_y);
      sum_model = sum_model - ring_model[slot_model] + dir;
      ring_model[slot_model] = dir;
      slot_model = (slot_model + 1) % RING_DEPTH;
      want.sample_direction  = dir;
      want.average_direction = HUND_W'(sum_model / RING_DEPTH);
      expected_directions.push_back(want);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   function automatic pressure_phase_type current_phase();
      return pressure_phase_type'((items_accepted / PHASE_ITEMS) % 4);
   endfunction

   function automatic bit chance(input int percent);
      return $urandom_range(0, 99) < percent;
   endfunction

   function automatic bit sender_idles();
      case (current_phase())
         PH_SENDER_GAPS: return chance(68);
         PH_BOTH_IDLE:   return chance(6);
         default:        return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (current_phase())
         PH_RECEIVER_STALLS: return chance(68);
         PH_BOTH_IDLE:       return chance(6);
         default:            return 1'b0;
      endcase
   endfunction

   function automatic int clamp_raw(input int v);
      return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
   endfunction

   task automatic queue_reading(input int x, input int y);
      req_item_type item;
      item.vane_x = RAW_W'(clamp_raw(x));
      item.vane_y = RAW_W'(clamp_raw(y));
      pending_readings.push_back(item);
   endtask

   // Fill the item queue: directed corners and axes, then random readings
   initial begin
      int x;
      int pick;
      for (int i = 0; i < RING_DEPTH; i++) ring_model[i] = '0;
      // corners, axes, the two readings nearest the center, diagonals
      queue_reading(0, 0);
      queue_reading(4095, 4095);
      queue_reading(0, 4095);
      queue_reading(4095, 0);
      queue_reading(4095, 2047);
      queue_reading(4095, 2048);
      queue_reading(2047, 4095);
      queue_reading(2048, 4095);
      queue_reading(0, 2047);
      queue_reading(0, 2048);
      queue_reading(2047, 0);
      queue_reading(2048, 0);
      queue_reading(2047, 2047);
      queue_reading(2048, 2048);
      queue_reading(2047, 2048);
      queue_reading(2048, 2047);
      queue_reading(3000, 3000);
      queue_reading(3000, 3001);
      queue_reading(3001, 3000);
      queue_reading(1000, 3095);
      queue_reading(3095, 1000);
      queue_reading(2049, 2046);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 9);
         x = $urandom_range(0, 4095);
         if (pick < 6) begin
            queue_reading(x, $urandom_range(0, 4095));
         end else if (pick < 8) begin
            // tiny vectors around the center
            queue_reading($urandom_range(2040, 2055), $urandom_range(2040, 2055));
         end else if (pick < 9) begin
            // near the diagonal that maps to north
            queue_reading(x, x + $urandom_range(0, 4) - 2);
         end else begin
            // near the anti-diagonal
            queue_reading(x, 4095 - x + $urandom_range(0, 4) - 2);
         end
      end
   end

   // Reset and end of run
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_readings.size() != 0 || req_valid || expected_directions.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_directions.size() != 0)
         report_mismatch("leftover expected results", 0, expected_directions.size());
      $display("Ran %0d vane items through steady, sender-gap, receiver-stall and mixed phases,",
               items_accepted);
      $display("compared %0d direction results, %0d mismatches.", results_checked,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_reading(req_data);
            items_accepted++;
         end
         // a stalled item holds its payload
         if (!req_valid || !req_stall) begin
            if (pending_readings.size() != 0 && !sender_idles()) begin
               req_valid <= 1'b1;
               req_data  <= pending_readings.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_directions.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.sample_direction, 0);
            end else begin
               want = expected_directions.pop_front();
               results_checked++;
               if (rsp_data.sample_direction !== want.sample_direction)
                  report_mismatch("sample_direction", rsp_data.sample_direction,
                                  want.sample_direction);
               if (rsp_data.average_direction !== want.average_direction)
                  report_mismatch("average_direction", rsp_data.average_direction,
                                  want.average_direction);
            end
         end
         rsp_stall <= receiver_stalls();
      end
   end

endmodule

### wind_vane_direction_averager_top.f
+incdir+hdl
hdl/wvda_pkg.sv
hdl/wvda_ram.sv
hdl/wvda_cordic.sv
hdl/wvda_ring.sv
hdl/wind_vane_direction_averager_top.sv
hdl/wvda_checker.sv
tb/testbench.sv
